// File: src/controller_replay_rle_codec_core_assert.svh
// Assertion macros for the replay codec core.
`ifndef CONTROLLER_REPLAY_RLE_CODEC_CORE_ASSERT_SVH
`define CONTROLLER_REPLAY_RLE_CODEC_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define CRRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("replay codec: same-cycle check failed");

// Next-cycle implication.
`define CRRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("replay codec: next-cycle check failed");

`else

`define CRRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define CRRC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/crrc_pkg.sv
`timescale 1ns / 1ps

package crrc_pkg;

  typedef enum logic [2:0] {
    ACT_START_REC  = 3'd0,
    ACT_RECORD     = 3'd1,
    ACT_START_PLAY = 3'd2,
    ACT_TICK       = 3'd3,
    ACT_LOAD       = 3'd4,
    ACT_READ       = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ADV,
    ST_OUT
  } state_t;

  typedef struct packed {
    action_t            action;
    logic signed [7:0]  stick_x;
    logic signed [7:0]  stick_y;
    logic [15:0]        buttons;
    logic               disqualify;
    logic [11:0]        address;
    logic [31:0]        load_data;
  } item_t;

  typedef struct packed {
    logic signed [7:0]  play_stick_x;
    logic signed [7:0]  play_stick_y;
    logic [15:0]        play_buttons;
    logic [15:0]        pressed_edges;
    logic [15:0]        released_edges;
    logic               playback_done;
    logic               cannot_save;
    logic [11:0]        record_position;
    logic [31:0]        read_data;
  } result_t;

  localparam logic [31:0] EMPTY_MARK = 32'hFFFF_FFFF;
  localparam logic [31:0] MATCH_MASK = 32'hFF00_FFFF;
  localparam logic [31:0] COUNT_ONE  = 32'h0001_0000;
  localparam logic [7:0]  COUNT_MAX  = 8'hFF;

endpackage

// File: src/crrc_stream_if.sv
`timescale 1ns / 1ps

interface crrc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/crrc_ram.sv
`timescale 1ns / 1ps

module crrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/controller_replay_rle_codec_core.sv
`timescale 1ns / 1ps
`include "controller_replay_rle_codec_core_assert.svh"

// Controller replay run-length codec. Records controller frames into a store
// of STORE_ENTRIES 32-bit run-length words (stick X, stick Y, run count and
// the A/B/Z/R buttons) and plays them back one tick per item, with pressed
// and released edges; load and read items give software access to the store.
// Every item returns exactly one result. The store sits in one RAM with a
// registered read, so an item passes through ST_IDLE (accept and read),
// ST_EXEC (execute and write back) and ST_OUT (load result, held while the
// result register is full) before the next acceptance; a playback tick that
// moves on to the next word also passes through ST_ADV, as the new word's
// count needs a second read. After reset the block clears the store to zero
// and accepts no item during that pass. The result register lets a new item be taken while the last result waits.

module controller_replay_rle_codec_core #(
  parameter int STORE_ENTRIES = 4096
) (
  input logic           clk,
  input logic           rst,
  crrc_stream_if.sink   req,
  crrc_stream_if.source rsp
);
  import crrc_pkg::*;

  localparam int IDX_W  = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
  localparam int PIDX_W = IDX_W + 1;
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(STORE_ENTRIES - 1);
  localparam logic [PIDX_W-1:0] END_IDX    = PIDX_W'(STORE_ENTRIES);
  localparam logic [31:0]       ENTRIES_32 = 32'(STORE_ENTRIES);

  state_t             state, state_next;
  item_t              item;
  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W-1:0]   record_index, record_index_next;
  logic [PIDX_W-1:0]  play_index, play_index_next;
  logic [7:0]         ticks_left, ticks_left_next;
  logic [3:0]         last_held, last_held_next;
  logic               save_blocked, save_blocked_next;
  logic               word0_empty;
  result_t            res, res_next;
  result_t            rsp_data;
  result_t            rsp_load;
  logic               rsp_valid;
  logic               rsp_free;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [31:0]        ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [31:0]        ram_rdata;

  logic [31:0]        frame_word;
  logic [3:0]         cur_held;
  logic [PIDX_W-1:0]  next_play;
  logic               addr_ok;

  function automatic logic [15:0] expand_buttons(input logic [3:0] h);
    return {h[3:1], 8'd0, h[0], 4'd0};
  endfunction

  crrc_ram #(
    .WIDTH (32),
    .DEPTH (STORE_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;
  assign rsp_free    = !rsp_valid || rsp.ready;

  // Count field of a fresh frame word is zero.
  assign frame_word = {item.buttons[15], item.buttons[14], item.buttons[13], item.buttons[4],
                       4'd0, 8'd0, item.stick_y, item.stick_x};
  assign cur_held   = ram_rdata[31:28];
  assign next_play  = play_index + PIDX_W'(1);
  assign addr_ok    = (32'(item.address) < ENTRIES_32);

  always_comb begin
    rsp_load                 = res;
    rsp_load.playback_done   = (play_index >= END_IDX);
    rsp_load.cannot_save     = save_blocked;
    rsp_load.record_position = 12'(record_index);
  end

  always_comb begin
    state_next        = state;
    record_index_next = record_index;
    play_index_next   = play_index;
    ticks_left_next   = ticks_left;
    last_held_next    = last_held;
    save_blocked_next = save_blocked;
    res_next          = res;
    ram_we            = 1'b0;
    ram_waddr         = record_index;
    ram_wdata         = '0;
    ram_raddr         = record_index;

    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // Issue the read for the item so its word arrives in ST_EXEC.
        case (req.payload.action)
          ACT_START_PLAY: ram_raddr = '0;
          ACT_TICK:       ram_raddr = IDX_W'(play_index);
          ACT_READ:       ram_raddr = IDX_W'(req.payload.address);
          default:        ram_raddr = record_index;
        endcase
        if (req.valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_OUT;
        res_next   = '0;
        case (item.action)
          ACT_START_REC: begin
            ram_we            = 1'b1;
            ram_waddr         = '0;
            ram_wdata         = EMPTY_MARK;
            record_index_next = '0;
            save_blocked_next = 1'b0;
          end

          ACT_RECORD: begin
            if (item.disqualify) begin
              save_blocked_next = 1'b1;
            end else if (word0_empty) begin
              ram_we    = 1'b1;
              ram_wdata = frame_word;
            end else if (((ram_rdata & MATCH_MASK) == frame_word) &&
                         (ram_rdata[23:16] != COUNT_MAX)) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata + COUNT_ONE;
            end else if (record_index == LAST_IDX) begin
              save_blocked_next = 1'b1;
            end else begin
              record_index_next = record_index + IDX_W'(1);
              ram_we            = 1'b1;
              ram_waddr         = record_index + IDX_W'(1);
              ram_wdata         = frame_word;
            end
          end

          ACT_START_PLAY: begin
            play_index_next   = '0;
            ticks_left_next   = ram_rdata[23:16];
            save_blocked_next = 1'b0;
          end

          ACT_TICK: begin
            if (play_index < END_IDX) begin
              res_next.play_stick_x   = ram_rdata[7:0];
              res_next.play_stick_y   = ram_rdata[15:8];
              res_next.play_buttons   = expand_buttons(cur_held);
              res_next.pressed_edges  = expand_buttons(cur_held & ~last_held);
              res_next.released_edges = expand_buttons(last_held & ~cur_held);
              last_held_next          = cur_held;
              if (ticks_left == 8'd0) begin
                play_index_next = next_play;
                if (next_play < END_IDX) begin
                  ram_raddr  = IDX_W'(next_play);
                  state_next = ST_ADV;
                end else begin
                  ticks_left_next = 8'd0;
                end
              end else begin
                ticks_left_next = ticks_left - 8'd1;
              end
            end
          end

          ACT_LOAD: begin
            if (addr_ok) begin
              ram_we    = 1'b1;
              ram_waddr = IDX_W'(item.address);
              ram_wdata = item.load_data;
            end
          end

          ACT_READ: begin
            if (addr_ok) begin
              res_next.read_data = ram_rdata;
            end
          end

          default: ;
        endcase
      end

      ST_ADV: begin
        ticks_left_next = ram_rdata[23:16];
        state_next      = ST_OUT;
      end

      ST_OUT: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      record_index <= '0;
      play_index   <= '0;
      ticks_left   <= '0;
      last_held    <= '0;
      save_blocked <= 1'b0;
      word0_empty  <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      record_index <= record_index_next;
      play_index   <= play_index_next;
      ticks_left   <= ticks_left_next;
      last_held    <= last_held_next;
      save_blocked <= save_blocked_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      // Track whether entry 0 holds the empty mark, saving a second read port.
      if (ram_we && (ram_waddr == '0)) begin
        word0_empty <= (ram_wdata == EMPTY_MARK);
      end
      if ((state == ST_OUT) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= req.payload;
    end
    res <= res_next;
    if ((state == ST_OUT) && rsp_free) begin
      rsp_data <= rsp_load;
    end
  end

  `CRRC_ASSERT_IMP(a_record_in_store, clk, rst, 1'b1, record_index <= LAST_IDX)
  `CRRC_ASSERT_IMP(a_play_bounded, clk, rst, 1'b1, play_index <= END_IDX)
  `CRRC_ASSERT_IMP(a_no_late_write, clk, rst, (state == ST_ADV) || (state == ST_OUT), !ram_we)
  `CRRC_ASSERT_NEXT(a_result_loaded, clk, rst, (state == ST_OUT) && rsp_free, rsp_valid)

endmodule
